// ===== hw/rtl/homogeneous_vertex_transform_core_defines.svh =====
// Assertion macros for the homogeneous vertex transform core.
// Used by the top level only; the bodies are empty when SYNTH is defined.
`ifndef HOMOGENEOUS_VERTEX_TRANSFORM_CORE_DEFINES_SVH
`define HOMOGENEOUS_VERTEX_TRANSFORM_CORE_DEFINES_SVH

`ifndef SYNTH
`define HVT_ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define HVT_ASSERT_DELAY(lbl, ante, dly, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##(dly) (cons)) \
    else $error("assertion failed");
`else
`define HVT_ASSERT_IMPLIES(lbl, ante, cons)
`define HVT_ASSERT_DELAY(lbl, ante, dly, cons)
`endif

`endif

// ===== hw/rtl/hvt_pkg.sv =====
// Package for the homogeneous vertex transform core: widths, item types and the
// bus that runs between the column cells. No dependencies.
`default_nettype none

package hvt_pkg;

  localparam int COEF_W    = 32;
  localparam int CFG_W     = 2 * COEF_W;
  localparam int NUM_ROWS  = 4;
  localparam int NUM_COLS  = 4;
  localparam int ROW_W     = 2;
  localparam int COL_W     = 2;
  localparam int CFG_IDX_W = 3;
  localparam int PROD_W    = 2 * COEF_W;
  localparam int ACC_W     = PROD_W + 2;
  localparam int FRAC_BITS = 16;
  localparam int SH_W      = ACC_W - FRAC_BITS;
  localparam int PIPE_LAT  = 2 * NUM_COLS + 1;

  localparam logic signed [COEF_W-1:0] COEF_ONE = COEF_W'(65536);
  localparam logic signed [COEF_W-1:0] SAT_MAX  = {1'b0, {(COEF_W-1){1'b1}}};
  localparam logic signed [COEF_W-1:0] SAT_MIN  = {1'b1, {(COEF_W-1){1'b0}}};

  typedef logic signed [ACC_W-1:0] acc_t;

  typedef struct packed {
    logic signed [COEF_W-1:0] in_x;
    logic signed [COEF_W-1:0] in_y;
    logic signed [COEF_W-1:0] in_z;
    logic signed [COEF_W-1:0] in_w;
  } in_item_t;

  typedef struct packed {
    logic signed [COEF_W-1:0] out_x;
    logic signed [COEF_W-1:0] out_y;
    logic signed [COEF_W-1:0] out_z;
    logic signed [COEF_W-1:0] out_w;
    logic                     overflow;
  } out_item_t;

  typedef struct packed {
    logic                      valid;
    in_item_t                  vec;
    acc_t [NUM_ROWS-1:0]       psum;
  } cell_bus_t;

endpackage

`default_nettype wire

// ===== hw/rtl/hvt_cell.sv =====
// One column cell: holds one matrix column, multiplies it by its vector component
// and adds the products to the running row sums. Depends on hvt_pkg.
`default_nettype none

module hvt_cell (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic [hvt_pkg::COL_W-1:0]          col_id,
  input  wire logic                               cfg_we,
  input  wire logic [hvt_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [hvt_pkg::CFG_W-1:0]          cfg_wdata,
  input  wire hvt_pkg::cell_bus_t                 bus_in,
  output hvt_pkg::cell_bus_t                      bus_out
);

  logic signed [hvt_pkg::COEF_W-1:0] coef_r   [hvt_pkg::NUM_ROWS];
  logic signed [hvt_pkg::COEF_W-1:0] vsel;
  logic signed [hvt_pkg::PROD_W-1:0] prod_nxt [hvt_pkg::NUM_ROWS];
  logic signed [hvt_pkg::PROD_W-1:0] a_prod_r [hvt_pkg::NUM_ROWS];
  hvt_pkg::acc_t                     a_psum_r [hvt_pkg::NUM_ROWS];
  hvt_pkg::acc_t                     psum_nxt [hvt_pkg::NUM_ROWS];
  hvt_pkg::acc_t                     b_psum_r [hvt_pkg::NUM_ROWS];
  hvt_pkg::in_item_t                 a_vec_r;
  hvt_pkg::in_item_t                 b_vec_r;
  logic                              a_valid_r;
  logic                              b_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < hvt_pkg::NUM_ROWS; r++) begin
        coef_r[r] <= (hvt_pkg::ROW_W'(r) == col_id) ? hvt_pkg::COEF_ONE : '0;
      end
    end else if (cfg_we) begin
      for (int r = 0; r < hvt_pkg::NUM_ROWS; r++) begin
        if (cfg_index == {hvt_pkg::ROW_W'(r), col_id[1]}) begin
          coef_r[r] <= col_id[0] ? cfg_wdata[hvt_pkg::COEF_W +: hvt_pkg::COEF_W]
                                 : cfg_wdata[0 +: hvt_pkg::COEF_W];
        end
      end
    end
  end

  always_comb begin
    case (col_id)
      2'd0:    vsel = bus_in.vec.in_x;
      2'd1:    vsel = bus_in.vec.in_y;
      2'd2:    vsel = bus_in.vec.in_z;
      default: vsel = bus_in.vec.in_w;
    endcase
    for (int r = 0; r < hvt_pkg::NUM_ROWS; r++) begin
      prod_nxt[r] = coef_r[r] * vsel;
      psum_nxt[r] = a_psum_r[r] + hvt_pkg::ACC_W'(a_prod_r[r]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
    end else begin
      a_valid_r <= bus_in.valid;
      b_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    a_vec_r <= bus_in.vec;
    b_vec_r <= a_vec_r;
    for (int r = 0; r < hvt_pkg::NUM_ROWS; r++) begin
      a_prod_r[r] <= prod_nxt[r];
      a_psum_r[r] <= bus_in.psum[r];
      b_psum_r[r] <= psum_nxt[r];
    end
  end

  always_comb begin
    bus_out.valid = b_valid_r;
    bus_out.vec   = b_vec_r;
    for (int r = 0; r < hvt_pkg::NUM_ROWS; r++) begin
      bus_out.psum[r] = b_psum_r[r];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/hvt_sat.sv =====
// Output stage: drops the fraction bits of each row sum, saturates to 32 bits and
// registers the result item with its strobe. Depends on hvt_pkg.
`default_nettype none

module hvt_sat (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire hvt_pkg::cell_bus_t bus_in,
  output logic                    out_valid,
  output hvt_pkg::out_item_t      out_item
);

  logic signed [hvt_pkg::SH_W-1:0]   sh;
  logic signed [hvt_pkg::COEF_W-1:0] res [hvt_pkg::NUM_ROWS];
  logic                              ovf_nxt;
  hvt_pkg::out_item_t                item_nxt;
  hvt_pkg::out_item_t                out_item_r;
  logic                              out_valid_r;

  always_comb begin
    ovf_nxt = 1'b0;
    sh      = '0;
    for (int r = 0; r < hvt_pkg::NUM_ROWS; r++) begin
      sh = $signed(bus_in.psum[r][hvt_pkg::ACC_W-1:hvt_pkg::FRAC_BITS]);
      if ((sh[hvt_pkg::SH_W-1:hvt_pkg::COEF_W-1] == '0) ||
          (sh[hvt_pkg::SH_W-1:hvt_pkg::COEF_W-1] == '1)) begin
        res[r] = sh[hvt_pkg::COEF_W-1:0];
      end else begin
        res[r]  = sh[hvt_pkg::SH_W-1] ? hvt_pkg::SAT_MIN : hvt_pkg::SAT_MAX;
        ovf_nxt = 1'b1;
      end
    end
    item_nxt.out_x    = res[0];
    item_nxt.out_y    = res[1];
    item_nxt.out_z    = res[2];
    item_nxt.out_w    = res[3];
    item_nxt.overflow = ovf_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= bus_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

`default_nettype wire

// ===== hw/rtl/homogeneous_vertex_transform_core.sv =====
// Top level of the homogeneous vertex transform core: a chain of four column
// cells and a saturating output stage; depends on hvt_pkg, hvt_cell, hvt_sat.
// A result strobes once its item has passed through every cell and the output register.
// Throughput: one item per cycle; each cell holds a multiply stage and an add stage.
// Reset loads the identity matrix and empties the pipeline; busy stays low.
// The receiver cannot stall, so nothing ever holds the chain.
`default_nettype none
`include "homogeneous_vertex_transform_core_defines.svh"

module homogeneous_vertex_transform_core (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire hvt_pkg::in_item_t             in_item,
  output logic                               out_valid,
  output hvt_pkg::out_item_t                 out_item,
  input  wire logic                          cfg_we,
  input  wire logic [hvt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [hvt_pkg::CFG_W-1:0]     cfg_wdata
);

  hvt_pkg::cell_bus_t chain_bus [hvt_pkg::NUM_COLS+1];

  assign busy = 1'b0;

  always_comb begin
    chain_bus[0].valid = start && !busy;
    chain_bus[0].vec   = in_item;
    chain_bus[0].psum  = '0;
  end

  for (genvar c = 0; c < hvt_pkg::NUM_COLS; c++) begin : g_cell
    hvt_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .col_id    (hvt_pkg::COL_W'(c)),
      .cfg_we    (cfg_we),
      .cfg_index (cfg_index),
      .cfg_wdata (cfg_wdata),
      .bus_in    (chain_bus[c]),
      .bus_out   (chain_bus[c+1])
    );
  end

  hvt_sat u_sat (
    .clk       (clk),
    .rst_n     (rst_n),
    .bus_in    (chain_bus[hvt_pkg::NUM_COLS]),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  function automatic logic is_sat(input logic [hvt_pkg::COEF_W-1:0] v);
    return (v == hvt_pkg::SAT_MAX) || (v == hvt_pkg::SAT_MIN);
  endfunction

  function automatic logic any_sat(input hvt_pkg::out_item_t o);
    return is_sat(o.out_x) || is_sat(o.out_y) || is_sat(o.out_z) || is_sat(o.out_w);
  endfunction

  `HVT_ASSERT_DELAY(a_item_gives_result, start && !busy, hvt_pkg::PIPE_LAT, out_valid)
  `HVT_ASSERT_IMPLIES(a_result_has_item, out_valid, $past(start && !busy, hvt_pkg::PIPE_LAT))
  `HVT_ASSERT_IMPLIES(a_overflow_saturates, out_valid && out_item.overflow, any_sat(out_item))

endmodule

`default_nettype wire
